/* rtl/core/isotp_seg_pkg.sv */
// Shared types and constants for the ISO-TP transmit segmenter.
package isotp_seg_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 29;

   localparam logic [CsrIndexWidth-1:0] CSR_TX_CAN_ID  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PAD_ENABLE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PAD_BYTE   = 2'd2;

   localparam logic [28:0] TX_CAN_ID_RESET  = 29'd2016;
   localparam logic        PAD_ENABLE_RESET = 1'b1;
   localparam logic [7:0]  PAD_BYTE_RESET   = 8'hCC;

   localparam logic [3:0] PCI_SINGLE      = 4'h0;
   localparam logic [3:0] PCI_FIRST       = 4'h1;
   localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

   localparam logic [2:0]  FF_DATA_BYTES  = 3'd6;
   localparam logic [2:0]  CF_DATA_BYTES  = 3'd7;
   localparam logic [11:0] SF_MAX_LENGTH  = 12'd7;
   localparam logic [3:0]  SEQ_START      = 4'h1;
   localparam logic [3:0]  FULL_FRAME_LEN = 4'd8;

   typedef struct packed {
      logic [55:0] frame_buffer;
      logic [2:0]  bytes_in_frame;
      logic [11:0] bytes_remaining;
      logic [11:0] latched_length;
      logic [3:0]  sequence_number;
      logic        first_frame_pending;
      logic        reject_mode;
   } seg_state_type;

   typedef struct packed {
      logic [28:0] tx_can_id;
      logic        pad_enable;
      logic [7:0]  pad_byte;
   } seg_cfg_type;

   typedef struct packed {
      logic        valid;
      logic [28:0] can_id;
      logic [63:0] frame_bytes;
      logic [3:0]  frame_length;
      logic        last_frame;
      logic        result_status;
   } seg_result_type;

endpackage

/* rtl/core/isotp_seg_step.sv */
// Per-item segmentation logic: next state and the optional frame for one byte.
module isotp_seg_step #(
   parameter int unsigned MAX_MESSAGE_BYTES = 4095
) (
   input  isotp_seg_pkg::seg_state_type  state_cur,
   input  isotp_seg_pkg::seg_cfg_type    cfg,
   input  logic [7:0]                    data_byte,
   input  logic [11:0]                   message_length,
   output isotp_seg_pkg::seg_state_type  state_nxt,
   output isotp_seg_pkg::seg_result_type result
);
   import isotp_seg_pkg::*;

   localparam logic [11:0] MaxLen = 12'(MAX_MESSAGE_BYTES);

   seg_state_type s;
   logic [2:0]    n;
   logic [2:0]    gap;
   logic [55:0]   body;
   logic [3:0]    pci_hi;
   logic [3:0]    pci_lo;
   logic          is_last;
   logic          is_single;

   always_comb begin
      s      = state_cur;
      result = '0;
      result.can_id = cfg.tx_can_id;
      n         = '0;
      gap       = '0;
      body      = '0;
      pci_hi    = '0;
      pci_lo    = '0;
      is_last   = 1'b0;
      is_single = 1'b0;

      // A new message starts when nothing is outstanding.
      if (s.bytes_remaining == '0) begin
         s.latched_length      = message_length;
         s.frame_buffer        = '0;
         s.bytes_in_frame      = '0;
         s.sequence_number     = SEQ_START;
         s.first_frame_pending = 1'b0;
         if (message_length == '0 || message_length > MaxLen) begin
            s.reject_mode     = 1'b1;
            s.bytes_remaining = (message_length == '0) ? 12'd1 : message_length;
         end else begin
            s.reject_mode         = 1'b0;
            s.first_frame_pending = (message_length > SF_MAX_LENGTH);
            s.bytes_remaining     = message_length;
         end
      end

      if (s.reject_mode) begin
         s.bytes_remaining = s.bytes_remaining - 12'd1;
         if (s.bytes_remaining == '0) begin
            s.reject_mode        = 1'b0;
            result.valid         = 1'b1;
            result.last_frame    = 1'b1;
            result.result_status = 1'b1;
         end
      end else begin
         s.frame_buffer    = {s.frame_buffer[47:0], data_byte};
         s.bytes_in_frame  = s.bytes_in_frame + 3'd1;
         s.bytes_remaining = s.bytes_remaining - 12'd1;

         if (s.first_frame_pending && s.bytes_in_frame == FF_DATA_BYTES) begin
            result.valid        = 1'b1;
            result.frame_bytes  = {PCI_FIRST, s.latched_length, s.frame_buffer[47:0]};
            result.frame_length = FULL_FRAME_LEN;
            s.first_frame_pending = 1'b0;
            s.frame_buffer        = '0;
            s.bytes_in_frame      = '0;
         end else if (s.bytes_remaining == '0 || s.bytes_in_frame == CF_DATA_BYTES) begin
            n         = s.bytes_in_frame;
            gap       = CF_DATA_BYTES - n;
            is_last   = (s.bytes_remaining == '0);
            is_single = (s.latched_length <= SF_MAX_LENGTH);
            // Left-align the collected bytes behind the PCI byte.
            body = s.frame_buffer << {gap, 3'b000};
            if (cfg.pad_enable) begin
               for (int k = 0; k < 7; k++) begin
                  if (3'(k) < gap) begin
                     body[8*k +: 8] = cfg.pad_byte;
                  end
               end
            end
            if (is_single) begin
               pci_hi = PCI_SINGLE;
               pci_lo = s.latched_length[3:0];
            end else begin
               pci_hi = PCI_CONSECUTIVE;
               pci_lo = s.sequence_number;
               s.sequence_number = is_last ? SEQ_START : s.sequence_number + 4'd1;
            end
            result.valid        = 1'b1;
            result.frame_bytes  = {pci_hi, pci_lo, body};
            result.frame_length = cfg.pad_enable ? FULL_FRAME_LEN : {1'b0, n} + 4'd1;
            result.last_frame   = is_last;
            s.frame_buffer      = '0;
            s.bytes_in_frame    = '0;
         end
      end

      state_nxt = s;
   end

endmodule

/* rtl/core/isotp_tx_segmenter_top.sv */
// Top level of the ISO-TP transmit segmenter for classic CAN frames.
module isotp_tx_segmenter_top #(
   parameter int unsigned MAX_MESSAGE_BYTES = 4095
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [7:0]                               req_data_byte,
   input  logic [11:0]                              req_message_length,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [28:0]                              rsp_can_id,
   output logic [63:0]                              rsp_frame_bytes,
   output logic [3:0]                               rsp_frame_length,
   output logic                                     rsp_last_frame,
   output logic                                     rsp_result_status,
   input  logic                                     csr_we,
   input  logic [isotp_seg_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [isotp_seg_pkg::CsrDataWidth-1:0]   csr_wdata
);
   // This block takes one payload byte per item, with the message length on the
   // first byte of each message, and emits ISO-TP frames for classic CAN. A
   // message of up to seven bytes leaves as one single frame; a longer one leaves
   // as a first frame with the 12-bit total length and six bytes, followed by
   // consecutive frames of up to seven bytes whose sequence number starts at one
   // and wraps modulo sixteen. Each frame appears as one result item in the cycle
   // after the item that carries its last byte is processed, so most items
   // produce no result. Too long or zero lengths are consumed silently and give
   // one status item with result_status set at the end. The block accepts one
   // item every clock cycle while the consumer does not stall: an input register
   // holds the byte, the segmentation step and the state update are a single
   // level of logic, and a result register presents the frame. When the result
   // register is held by a stalled consumer, processing stops and the input
   // register fills, after which req_ready drops. The configuration registers may
   // be written only while no message is in flight.
   import isotp_seg_pkg::*;

   seg_cfg_type    cfg_ff;
   seg_state_type  state_ff;
   seg_state_type  state_in;
   seg_result_type step_result;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [11:0] in_length_ff;
   logic        in_take;
   logic        advance;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [28:0] out_can_id_ff;
   logic [63:0] out_bytes_ff;
   logic [3:0]  out_length_ff;
   logic        out_last_ff;
   logic        out_status_ff;

   // The item in the input register moves on whenever the result register can
   // take whatever it produces.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_take     = req_valid && req_ready;
   assign in_valid_in = in_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && step_result.valid) || (out_valid_ff && !rsp_ready);

   isotp_seg_step #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_step (
      .state_cur      (state_ff),
      .cfg            (cfg_ff),
      .data_byte      (in_byte_ff),
      .message_length (in_length_ff),
      .state_nxt      (state_in),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_can_id  <= TX_CAN_ID_RESET;
         cfg_ff.pad_enable <= PAD_ENABLE_RESET;
         cfg_ff.pad_byte   <= PAD_BYTE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TX_CAN_ID:  cfg_ff.tx_can_id  <= csr_wdata[28:0];
            CSR_PAD_ENABLE: cfg_ff.pad_enable <= csr_wdata[0];
            CSR_PAD_BYTE:   cfg_ff.pad_byte   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{frame_buffer: '0, bytes_in_frame: '0, bytes_remaining: '0,
                           latched_length: '0, sequence_number: SEQ_START,
                           first_frame_pending: 1'b0, reject_mode: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_byte_ff   <= req_data_byte;
         in_length_ff <= req_message_length;
      end
      if (advance && step_result.valid) begin
         out_can_id_ff <= step_result.can_id;
         out_bytes_ff  <= step_result.frame_bytes;
         out_length_ff <= step_result.frame_length;
         out_last_ff   <= step_result.last_frame;
         out_status_ff <= step_result.result_status;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_can_id        = out_can_id_ff;
   assign rsp_frame_bytes   = out_bytes_ff;
   assign rsp_frame_length  = out_length_ff;
   assign rsp_last_frame    = out_last_ff;
   assign rsp_result_status = out_status_ff;

endmodule
